>>> rtl/core/mwz_pkg.sv
// Shared types and constants of the multi-window rolling z-score block.
`default_nettype none
package mwz_pkg;

  localparam int unsigned PRICE_W        = 24;
  localparam int unsigned Z_W            = 24;
  localparam int unsigned LEN_W          = 9;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned SQ_W           = 56;
  localparam int unsigned MAX_LEN        = 256;
  localparam int unsigned HIST_DEPTH_DEF = 256;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned DIV_STEPS      = 96;
  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned STEP_W         = 7;

  localparam logic [LEN_W-1:0] SHORT_RST  = 9'd16;
  localparam logic [LEN_W-1:0] MEDIUM_RST = 9'd64;
  localparam logic [LEN_W-1:0] LONG_RST   = 9'd256;

  localparam logic signed [Z_W-1:0] Z_MAX = 24'sh7FFFFF;
  localparam logic signed [Z_W-1:0] Z_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT  = 2'd0,
    CFG_MEDIUM = 2'd1,
    CFG_LONG   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_OLD,
    OP_SQ_OLD,
    OP_UPD,
    OP_WRITE,
    OP_RD_NEW,
    OP_LAT_NEW,
    OP_ZMUL,
    OP_ZDIFF,
    OP_ZSQ,
    OP_DIV,
    OP_SQI,
    OP_SQRT,
    OP_FIN,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e                op;
    logic [CFG_IDX_W-1:0]  win;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OLD,
    S_SQ_OLD,
    S_UPD,
    S_WRITE,
    S_RD_NEW,
    S_LAT_NEW,
    S_ZMUL,
    S_ZDIFF,
    S_ZSQ,
    S_DIV,
    S_SQI,
    S_SQRT,
    S_FIN,
    S_EMIT
  } ctrl_state_e;

endpackage
`default_nettype wire

>>> rtl/core/mwz_datapath.sv
// Datapath: price history, running sums, z-score divider and square root.
`default_nettype none
module mwz_datapath #(
  parameter int unsigned HistDepth = mwz_pkg::HIST_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mwz_pkg::dp_cmd_t                  cmd_i,
  input  wire logic [mwz_pkg::PRICE_W-1:0]       price_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [mwz_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mwz_pkg::LEN_W-1:0]         cfg_data_i,
  output logic [3*mwz_pkg::Z_W-1:0]              out_data_o
);
  import mwz_pkg::*;

  localparam int unsigned AW = $clog2(HistDepth);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned CapLen = (HistDepth < MAX_LEN) ? HistDepth : MAX_LEN;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(CapLen)) r = LEN_W'(CapLen);
    return r;
  endfunction

  logic [LEN_W-1:0]     len_q [3];
  logic [SUM_W-1:0]     sum_q [3];
  logic [SQ_W-1:0]      sq_q  [3];
  logic [AW-1:0]        ws_q;
  logic [LEN_W-1:0]     fill_q;
  logic [PRICE_W-1:0]   mem [HistDepth];
  logic [PRICE_W-1:0]   mem_q;
  logic [PRICE_W-1:0]   p_q, old_q, newest_q;
  logic [2*PRICE_W-1:0] psq_q, oldsq_q;
  logic [PRICE_W+LEN_W-1:0] np_q;
  logic [63:0]          nq_q, ss_q, d_q, rem_q, dvd_q, quo_q, rad_q;
  logic [31:0]          num_q, root_q;
  logic [33:0]          srem_q;
  logic                 neg_q, zero_q, ovf_q;
  logic [Z_W-1:0]       res_q [3];
  logic [3*Z_W-1:0]     out_q;

  logic [LEN_W-1:0]     n_sel, longest;
  logic [SUM_W-1:0]     s_sel;
  logic [SQ_W-1:0]      q_sel;
  logic                 fill_ge;
  logic [IW-1:0]        ws_ext, off, rd_sum;
  logic [AW-1:0]        rd_addr;
  logic [SUM_W-1:0]     s_new;
  logic [SQ_W-1:0]      q_new;
  logic [64:0]          nq_full;
  logic [63:0]          ss_full, num2;
  logic [PRICE_W+LEN_W-1:0] np_full;
  logic [PRICE_W+LEN_W-1:0] s_ext;
  logic [64:0]          r65, d65;
  logic                 div_ge;
  logic [35:0]          t36, trial;
  logic                 sq_ge;
  logic                 sat;
  logic signed [Z_W-1:0] z;

  always_comb begin
    unique case (cmd_i.win)
      CFG_SHORT:  n_sel = eff_len(len_q[0]);
      CFG_MEDIUM: n_sel = eff_len(len_q[1]);
      CFG_LONG:   n_sel = eff_len(len_q[2]);
      default:    n_sel = eff_len(len_q[2]);
    endcase
    unique case (cmd_i.win)
      CFG_SHORT:  begin s_sel = sum_q[0]; q_sel = sq_q[0]; end
      CFG_MEDIUM: begin s_sel = sum_q[1]; q_sel = sq_q[1]; end
      default:    begin s_sel = sum_q[2]; q_sel = sq_q[2]; end
    endcase
    longest = eff_len(len_q[2]);
    fill_ge = fill_q >= n_sel;

    ws_ext = IW'(ws_q);
    off    = (cmd_i.op == OP_RD_NEW) ? IW'(1) : IW'(n_sel);
    if (ws_ext >= off) rd_sum = ws_ext - off;
    else rd_sum = ws_ext + IW'(HistDepth) - off;
    rd_addr = rd_sum[AW-1:0];

    s_new = sum_q[0];
    q_new = sq_q[0];
    s_new = s_sel + SUM_W'(p_q) - (fill_ge ? SUM_W'(old_q) : '0);
    q_new = q_sel + SQ_W'(psq_q) - (fill_ge ? SQ_W'(oldsq_q) : '0);

    nq_full = 65'(n_sel) * 65'(q_sel);
    ss_full = 64'(s_sel) * 64'(s_sel);
    np_full = (PRICE_W+LEN_W)'(n_sel) * (PRICE_W+LEN_W)'(newest_q);
    s_ext   = (PRICE_W+LEN_W)'(s_sel);
    num2    = 64'(num_q) * 64'(num_q);

    r65    = {rem_q, dvd_q[63]};
    d65    = {1'b0, d_q};
    div_ge = r65 >= d65;

    t36   = {srem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    sq_ge = t36 >= trial;

    sat = ovf_q | quo_q[63];
    if (zero_q) z = '0;
    else if (sat) z = neg_q ? Z_MIN : Z_MAX;
    else if (neg_q) z = (root_q > 32'd8388608) ? Z_MIN : -$signed(root_q[Z_W-1:0]);
    else z = (root_q > 32'd8388607) ? Z_MAX : $signed(root_q[Z_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) mem[ws_q] <= p_q;
    if (cmd_i.op == OP_RD_OLD || cmd_i.op == OP_RD_NEW) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0] <= SHORT_RST;
      len_q[1] <= MEDIUM_RST;
      len_q[2] <= LONG_RST;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        sq_q[i]  <= '0;
      end
      ws_q   <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SHORT || cfg_idx_i == CFG_MEDIUM || cfg_idx_i == CFG_LONG) begin
        len_q[cfg_idx_i] <= cfg_data_i;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
          sq_q[i]  <= '0;
        end
        ws_q   <= '0;
        fill_q <= '0;
      end
    end else if (cmd_i.op == OP_UPD) begin
      sum_q[cmd_i.win] <= s_new;
      sq_q[cmd_i.win]  <= q_new;
    end else if (cmd_i.op == OP_WRITE) begin
      ws_q <= (ws_q == AW'(HistDepth - 1)) ? '0 : ws_q + AW'(1);
      if (fill_q < longest) fill_q <= fill_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        p_q   <= price_i;
        psq_q <= (2*PRICE_W)'(price_i) * (2*PRICE_W)'(price_i);
      end
      OP_SQ_OLD: begin
        old_q   <= mem_q;
        oldsq_q <= (2*PRICE_W)'(mem_q) * (2*PRICE_W)'(mem_q);
      end
      OP_LAT_NEW: newest_q <= mem_q;
      OP_ZMUL: begin
        np_q   <= np_full;
        nq_q   <= nq_full[63:0];
        ss_q   <= ss_full;
        zero_q <= !fill_ge;
      end
      OP_ZDIFF: begin
        d_q   <= nq_q - ss_q;
        neg_q <= np_q < s_ext;
        num_q <= (np_q < s_ext) ? 32'(s_ext - np_q) : 32'(np_q - s_ext);
      end
      OP_ZSQ: begin
        dvd_q  <= num2;
        zero_q <= zero_q | (d_q == '0);
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end
      OP_DIV: begin
        rem_q <= div_ge ? 64'(r65 - d65) : r65[63:0];
        dvd_q <= {dvd_q[62:0], 1'b0};
        ovf_q <= ovf_q | quo_q[63];
        quo_q <= {quo_q[62:0], div_ge};
      end
      OP_SQI: begin
        rad_q  <= quo_q;
        root_q <= '0;
        srem_q <= '0;
      end
      OP_SQRT: begin
        srem_q <= sq_ge ? 34'(t36 - trial) : t36[33:0];
        root_q <= {root_q[30:0], sq_ge};
        rad_q  <= {rad_q[61:0], 2'b00};
      end
      OP_FIN: res_q[cmd_i.win] <= z;
      OP_EMIT: out_q <= {res_q[2], res_q[1], res_q[0]};
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

>>> rtl/core/mwz_ctrl.sv
// Controller: sequences sum updates and per-window z-score steps.
`default_nettype none
module mwz_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           in_has_i,
  input  wire logic           in_end_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mwz_pkg::dp_cmd_t    cmd_o
);
  import mwz_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [CFG_IDX_W-1:0] win_q, win_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 end_q, end_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= '0;
      step_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      step_q      <= step_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    step_d      = step_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NOP;
    cmd_o.win   = win_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          end_d    = in_end_i;
          win_d    = CFG_SHORT;
          if (in_has_i) state_d = S_RD_OLD;
          else if (in_end_i) state_d = S_RD_NEW;
        end
      end
      S_RD_OLD: begin
        cmd_o.op = OP_RD_OLD;
        state_d  = S_SQ_OLD;
      end
      S_SQ_OLD: begin
        cmd_o.op = OP_SQ_OLD;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        if (win_q == CFG_LONG) begin
          state_d = S_WRITE;
        end else begin
          win_d   = win_q + CFG_IDX_W'(1);
          state_d = S_RD_OLD;
        end
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        win_d    = CFG_SHORT;
        state_d  = end_q ? S_RD_NEW : S_IDLE;
      end
      S_RD_NEW: begin
        cmd_o.op = OP_RD_NEW;
        state_d  = S_LAT_NEW;
      end
      S_LAT_NEW: begin
        cmd_o.op = OP_LAT_NEW;
        win_d    = CFG_SHORT;
        state_d  = S_ZMUL;
      end
      S_ZMUL: begin
        cmd_o.op = OP_ZMUL;
        state_d  = S_ZDIFF;
      end
      S_ZDIFF: begin
        cmd_o.op = OP_ZDIFF;
        state_d  = S_ZSQ;
      end
      S_ZSQ: begin
        cmd_o.op = OP_ZSQ;
        step_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_SQI;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_SQI: begin
        cmd_o.op = OP_SQI;
        step_d   = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        if (win_q == CFG_LONG) begin
          state_d = S_EMIT;
        end else begin
          win_d   = win_q + CFG_IDX_W'(1);
          state_d = S_ZMUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_has_i && !in_end_i) |=> (state_q == S_IDLE))
    else $error("empty item did not return to idle");
  a_last_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && win_q == CFG_LONG) |=> (state_q == S_EMIT))
    else $error("missing emit after last window");
  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != 2'd3))
    else $error("window index out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/core/multi_window_rolling_zscore.sv
// Top level of the multi-window rolling z-score block.
// Usage:
//   s_axis: one item per trade; tdata = price_ticks, tuser = has_price,
//   tlast = batch_end. has_price appends the price to the history; batch_end
//   produces one result on m_axis after the item is processed.
//   m_axis: tdata = {long_z, medium_z, short_z}, each signed Q7.16, saturated.
//   cfg: index 0/1/2 writes short/medium/long length; each such write clears the
//   history and running sums. Write only while the block is idle.
// Sequence: an item with a price is accepted, then goes per window through a
//   memory read, a square and an update, then the history write.
//   A batch end then reads the newest price and runs, per window, a
//   96-step restoring divider and a 32-step square root, one bit per cycle,
//   shared by windows, then loads the output register.
//   An item with neither flag returns to idle once accepted. One item is in work at a time.
// Reset: lengths return to 16/64/256, history and sums are empty.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile, and a new result waits until the held one is taken.
`default_nettype none
module multi_window_rolling_zscore #(
  parameter int unsigned HistDepth = mwz_pkg::HIST_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [mwz_pkg::PRICE_W-1:0]       s_axis_tdata,   // price_ticks
  input  wire logic                              s_axis_tuser,   // has_price
  input  wire logic                              s_axis_tlast,   // batch_end
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [3*mwz_pkg::Z_W-1:0]              m_axis_tdata,   // short_z, medium_z, long_z
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mwz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mwz_pkg::LEN_W-1:0]         cfg_data_i
);
  import mwz_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  mwz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_has_i    (s_axis_tuser),
    .in_end_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mwz_datapath #(
    .HistDepth (HistDepth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .price_i    (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> verif/zscore_checker.sv
// Checker for the rolling z-score block: predicts results from accepted items and compares them.
module zscore_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [mwz_pkg::PRICE_W-1:0]       s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [3*mwz_pkg::Z_W-1:0]         m_axis_tdata,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [mwz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mwz_pkg::LEN_W-1:0]         cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mwz_pkg::*;

  typedef struct packed {
    logic [Z_W-1:0] long_z;
    logic [Z_W-1:0] medium_z;
    logic [Z_W-1:0] short_z;
  } zscores_t;

  zscores_t expected_scores[$];

  logic [PRICE_W-1:0] hist[MAX_LEN];
  int unsigned        wslot;
  int unsigned        fill;
  logic [SUM_W-1:0]   psum[3];
  logic [SQ_W-1:0]    qsum[3];
  logic [LEN_W-1:0]   lens[3];

  assign pending_o = expected_scores.size();

  function automatic int unsigned eff_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return v;
  endfunction

  function automatic logic [Z_W-1:0] window_z(int unsigned n, logic [SUM_W-1:0] s,
                                              logic [SQ_W-1:0] q, logic [PRICE_W-1:0] newest,
                                              int unsigned filled);
    logic [63:0] n64, s64, q64, d, np, num, num2, quo, rem, frac, r, res, bt, x;
    logic neg, top;
    if (filled < n) return '0;
    n64 = n;
    s64 = s;
    q64 = q;
    if ((q64 / n64) > ((64'hFFFF_FFFF_FFFF_FFFF / n64) / n64)) return '0;
    if (n64 * q64 < s64 * s64) return '0;
    d = n64 * q64 - s64 * s64;
    if (d == 0) return '0;
    np = n64 * {40'd0, newest};
    neg = np < s64;
    num = neg ? s64 - np : np - s64;
    num2 = num * num;
    quo = num2 / d;
    rem = num2 % d;
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      top = rem[63];
      rem = rem << 1;
      frac = frac << 1;
      if (top || rem >= d) begin
        rem = rem - d;
        frac[0] = 1'b1;
      end
    end
    if (quo >= 64'h8000_0000) return neg ? Z_MIN : Z_MAX;
    r = (quo << 32) | frac;
    x = r;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (neg) return (res > 64'd8388608) ? Z_MIN : Z_W'(-res);
    return (res > 64'd8388607) ? Z_MAX : Z_W'(res);
  endfunction

  task automatic clear_history();
    foreach (hist[i]) hist[i] = '0;
    wslot = 0;
    fill = 0;
    for (int w = 0; w < 3; w++) begin
      psum[w] = '0;
      qsum[w] = '0;
    end
  endtask

  task automatic predict_trade(logic [PRICE_W-1:0] p, logic has_p, logic last);
    int unsigned n, idx;
    logic [63:0] sq, oldp;
    zscores_t z;
    logic [PRICE_W-1:0] newest;
    if (has_p) begin
      for (int w = 0; w < 3; w++) begin
        n = eff_len(lens[w]);
        sq = {40'd0, p} * {40'd0, p};
        if (fill >= n) begin
          idx = (wslot + MAX_LEN - n) % MAX_LEN;
          oldp = {40'd0, hist[idx]};
          psum[w] = psum[w] + p - oldp[31:0];
          qsum[w] = qsum[w] + sq[55:0] - SQ_W'(oldp * oldp);
        end else begin
          psum[w] = psum[w] + p;
          qsum[w] = qsum[w] + sq[55:0];
        end
      end
      hist[wslot] = p;
      wslot = (wslot + 1) % MAX_LEN;
      if (fill < eff_len(lens[2])) fill++;
    end
    if (last) begin
      newest = hist[(wslot + MAX_LEN - 1) % MAX_LEN];
      z.short_z  = window_z(eff_len(lens[0]), psum[0], qsum[0], newest, fill);
      z.medium_z = window_z(eff_len(lens[1]), psum[1], qsum[1], newest, fill);
      z.long_z   = window_z(eff_len(lens[2]), psum[2], qsum[2], newest, fill);
      expected_scores.insert(expected_scores.size(), z);
    end
  endtask

  task automatic check_field(string name, logic [Z_W-1:0] exp_v, logic [Z_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    zscores_t got, exp_z;
    if (!rst_ni) begin
      clear_history();
      lens[0] = SHORT_RST;
      lens[1] = MEDIUM_RST;
      lens[2] = LONG_RST;
      expected_scores.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_scores.size() == 0) begin
          $error("unexpected result item");
          fail_count_o++;
        end else begin
          exp_z = expected_scores[0];
          expected_scores.delete(0);
          check_field("short_z", exp_z.short_z, got.short_z);
          check_field("medium_z", exp_z.medium_z, got.medium_z);
          check_field("long_z", exp_z.long_z, got.long_z);
        end
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i <= CFG_LONG) begin
        lens[cfg_index_i] = cfg_data_i;
        clear_history();
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_trade(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end
endmodule

>>> verif/tb_top.sv
// Testbench top for the rolling z-score block: stimulus, idling, watchdog and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwz_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [PRICE_W-1:0]   s_axis_tdata;   // price_ticks
  logic                 s_axis_tuser;   // has_price
  logic                 s_axis_tlast;   // batch_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [3*Z_W-1:0]     m_axis_tdata;   // short_z, medium_z, long_z
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LEN_W-1:0]     cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  int                   burst_left;
  int                   stall_mode = 0;
  int                   stall_left = 0;

  multi_window_rolling_zscore u_dut (.*);

  zscore_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i,
    .cfg_ready_o, .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_trade(logic [PRICE_W-1:0] p, logic has_p, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tuser  <= has_p;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left <= 1) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_len(cfg_idx_e idx, logic [LEN_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_lengths(logic [LEN_W-1:0] s, logic [LEN_W-1:0] m, logic [LEN_W-1:0] l);
    wait_drained();
    write_len(CFG_SHORT, s);
    write_len(CFG_MEDIUM, m);
    write_len(CFG_LONG, l);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int items);
    int mode;
    int base;
    int p;
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, 24'hFFFFFF);
    for (int i = 0; i < items; i++) begin
      case (mode)
        0: p = $urandom_range(0, 24'hFFFFFF);
        1: p = base;
        default: begin
          p = base + $urandom_range(0, 512) - 256;
          if (p < 0) p = 0;
          if (p > 24'hFFFFFF) p = 24'hFFFFFF;
        end
      endcase
      if ($urandom_range(0, 40) == 0) p = $urandom_range(0, 24'hFFFFFF);
      send_trade(PRICE_W'(p), $urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_SHORT;
    cfg_data_i    <= '0;
    burst_left = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_trade(24'd0, 1'b0, 1'b1);
    send_trade(24'hFFFFFF, 1'b1, 1'b1);
    send_trade(24'd0, 1'b1, 1'b0);
    send_trade(24'd0, 1'b0, 1'b0);
    for (int i = 0; i < 14; i++) send_trade((i % 2 == 1) ? 24'hFFFFFF : 24'd0, 1'b1, 1'b0);
    send_trade(24'h123456, 1'b1, 1'b1);

    set_lengths(9'd1, 9'd2, 9'd3);
    send_trade(24'd5, 1'b1, 1'b0);
    send_trade(24'd5, 1'b1, 1'b0);
    send_trade(24'd5, 1'b1, 1'b1);
    send_trade(24'd9, 1'b1, 1'b1);
    send_trade(24'd0, 1'b0, 1'b1);
    wait_drained();
    write_len(cfg_idx_e'(3), 9'd7);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_trade(24'd2, 1'b1, 1'b1);

    set_lengths(9'd0, 9'd511, 9'd300);
    run_phase(320);
    set_lengths(9'd40, 9'd20, 9'd8);
    run_phase(200);
    set_lengths(9'd1, 9'd256, 9'd256);
    run_phase(320);
    for (int ph = 0; ph < 6; ph++) begin
      set_lengths(LEN_W'($urandom_range(1, 24)), LEN_W'($urandom_range(1, 48)),
                  LEN_W'($urandom_range(1, 64)));
      run_phase(190);
    end

    wait_drained();
    repeat (450) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
